/* src/anagram_window_search_macros.svh */
// assertion macros for the anagram window search checker
`ifndef ANAGRAM_WINDOW_SEARCH_MACROS_SVH
`define ANAGRAM_WINDOW_SEARCH_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define AWS_ASSERT_NOW(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("aws checker: property violated");

// next-cycle implication, sampled on clk, off during reset
`define AWS_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("aws checker: property violated");

`endif

/* src/aws_pkg.sv */
// types and constants shared by the anagram window search block
`default_nettype none

package aws_pkg;

	localparam int LETTERS     = 26;
	localparam int LW          = 5;
	localparam int QUEUE_DEPTH = 2;

	typedef logic [1:0] kind_t;

	localparam kind_t KIND_CLEAR   = 2'd0;
	localparam kind_t KIND_PATTERN = 2'd1;
	localparam kind_t KIND_TEXT    = 2'd2;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_CLEAR,
		OP_PATTERN,
		OP_TEXT_OPEN,
		OP_TEXT
	} op_code_t;

	typedef struct packed {
		kind_t         kind;
		logic [LW-1:0] letter;
	} item_t;

	typedef struct packed {
		logic match_here;
		logic found;
	} result_t;

	typedef struct packed {
		op_code_t      code;
		logic [LW-1:0] letter;
		logic          leave;
	} op_t;

	typedef struct packed {
		op_t           op;
		logic [LW-1:0] old_letter;
	} qent_t;

endpackage

`default_nettype wire

/* src/aws_stream_if.sv */
// valid/ready stream interface carrying one beat of payload
`default_nettype none

interface aws_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* src/aws_front.sv */
// front end: accepts beats, tracks pattern and ring state, reads the history ring
`default_nettype none

module aws_front #(
	parameter int MAX_PATTERN = 64
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire aws_pkg::item_t in_data,
	output logic                push_valid,
	input  wire logic           push_ready,
	output aws_pkg::qent_t      push_data
);

	localparam int PW = $clog2(MAX_PATTERN + 1);
	localparam int RW = PW + 1;
	localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

	logic [aws_pkg::LW-1:0] ring_mem [MAX_PATTERN];

	logic [PW-1:0]          plen_q;
	logic [PW-1:0]          seen_q;
	logic [AW-1:0]          head_q;
	logic                   valid_s1;
	aws_pkg::op_t           op_s1;
	logic [aws_pkg::LW-1:0] old_s1;

	aws_pkg::op_t  op;
	logic          accept;
	logic          letter_ok;
	logic [RW-1:0] back_sum;
	logic [RW-1:0] back_slot;
	logic [AW-1:0] raddr;
	logic [AW-1:0] head_next;

	assign in_ready   = !valid_s1 || push_ready;
	assign accept     = in_valid && in_ready;
	assign push_valid = valid_s1;
	assign push_data  = '{op: op_s1, old_letter: old_s1};

	assign letter_ok = in_data.letter < aws_pkg::LW'(aws_pkg::LETTERS);

	always_comb begin
		op.code   = aws_pkg::OP_NONE;
		op.letter = in_data.letter;
		op.leave  = 1'b0;
		case (in_data.kind)
			aws_pkg::KIND_CLEAR: begin
				op.code = aws_pkg::OP_CLEAR;
			end
			aws_pkg::KIND_PATTERN: begin
				if (letter_ok && seen_q == '0 && plen_q < PW'(MAX_PATTERN)) begin
					op.code = aws_pkg::OP_PATTERN;
				end
			end
			aws_pkg::KIND_TEXT: begin
				if (letter_ok) begin
					if (plen_q == '0) begin
						op.code = aws_pkg::OP_TEXT_OPEN;
					end else begin
						op.code  = aws_pkg::OP_TEXT;
						op.leave = seen_q == plen_q;
					end
				end
			end
			default: begin
				op.code = aws_pkg::OP_NONE;
			end
		endcase
	end

	// slot of the letter pattern-length places back
	always_comb begin
		back_sum  = RW'(head_q) + RW'(MAX_PATTERN) - RW'(plen_q);
		back_slot = (back_sum >= RW'(MAX_PATTERN)) ? back_sum - RW'(MAX_PATTERN) : back_sum;
		raddr     = back_slot[AW-1:0];
		head_next = (head_q == AW'(MAX_PATTERN - 1)) ? '0 : head_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			plen_q   <= '0;
			seen_q   <= '0;
			head_q   <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (accept) begin
				case (op.code)
					aws_pkg::OP_CLEAR: begin
						plen_q <= '0;
						seen_q <= '0;
						head_q <= '0;
					end
					aws_pkg::OP_PATTERN: begin
						plen_q <= plen_q + 1'b1;
					end
					aws_pkg::OP_TEXT: begin
						head_q <= head_next;
						if (!op.leave) begin
							seen_q <= seen_q + 1'b1;
						end
					end
					default: begin
						plen_q <= plen_q;
					end
				endcase
			end
		end
	end

	// history ring, read before write on a shared slot
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1  <= op;
			old_s1 <= ring_mem[raddr];
			if (op.code == aws_pkg::OP_TEXT) begin
				ring_mem[head_q] <= in_data.letter;
			end
		end
	end

endmodule

`default_nettype wire

/* src/aws_queue.sv */
// short queue between front and back end
`default_nettype none

module aws_queue #(
	parameter type T = logic
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push_valid,
	output logic      push_ready,
	input  wire T     push_data,
	output logic      pop_valid,
	input  wire logic pop_ready,
	output T          pop_data
);

	localparam int QAW = $clog2(aws_pkg::QUEUE_DEPTH);

	T             entry_q [aws_pkg::QUEUE_DEPTH];
	logic [QAW-1:0] wptr_q;
	logic [QAW-1:0] rptr_q;
	logic [QAW:0]   count_q;

	logic push;
	logic pop;

	assign push_ready = count_q != (QAW + 1)'(aws_pkg::QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_data   = entry_q[rptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == QAW'(aws_pkg::QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == QAW'(aws_pkg::QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

/* src/aws_back.sv */
// back end: per-letter difference cells, found flag and result register
`default_nettype none

module aws_back #(
	parameter int MAX_PATTERN = 64
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           pop_valid,
	output logic                pop_ready,
	input  wire aws_pkg::qent_t pop_data,
	output logic                res_valid,
	input  wire logic           res_ready,
	output aws_pkg::result_t    res_data
);

	localparam int DW = $clog2(MAX_PATTERN + 1) + 1;

	// window count minus pattern count, one cell per letter
	logic signed [DW-1:0] diff_q    [aws_pkg::LETTERS];
	logic signed [DW-1:0] diff_next [aws_pkg::LETTERS];
	logic [aws_pkg::LETTERS-1:0] nonzero;

	logic             found_q;
	logic             res_valid_q;
	aws_pkg::result_t res_q;

	logic take;
	logic is_text;
	logic is_pat;
	logic match;
	logic found_next;

	assign pop_ready = !res_valid_q || res_ready;
	assign take      = pop_valid && pop_ready;
	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	assign is_text = pop_data.op.code == aws_pkg::OP_TEXT;
	assign is_pat  = pop_data.op.code == aws_pkg::OP_PATTERN;

	always_comb begin
		logic inc;
		logic dec;
		for (int k = 0; k < aws_pkg::LETTERS; k++) begin
			inc = is_text && pop_data.op.letter == aws_pkg::LW'(k);
			dec = (is_text && pop_data.op.leave && pop_data.old_letter == aws_pkg::LW'(k))
				|| (is_pat && pop_data.op.letter == aws_pkg::LW'(k));
			diff_next[k] = diff_q[k] + DW'(inc) - DW'(dec);
			nonzero[k]   = diff_next[k] != '0;
		end
	end

	always_comb begin
		unique case (pop_data.op.code)
			aws_pkg::OP_TEXT:      match = ~|nonzero;
			aws_pkg::OP_TEXT_OPEN: match = 1'b1;
			default:               match = 1'b0;
		endcase
		found_next = (pop_data.op.code == aws_pkg::OP_CLEAR) ? 1'b0 : (found_q | match);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			found_q     <= 1'b0;
			for (int k = 0; k < aws_pkg::LETTERS; k++) begin
				diff_q[k] <= '0;
			end
		end else begin
			if (pop_ready) begin
				res_valid_q <= pop_valid;
			end
			if (take) begin
				found_q <= found_next;
				for (int k = 0; k < aws_pkg::LETTERS; k++) begin
					diff_q[k] <= (pop_data.op.code == aws_pkg::OP_CLEAR) ? '0 : diff_next[k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= '{match_here: match, found: found_next};
		end
	end

endmodule

`default_nettype wire

/* src/anagram_window_search.sv */
// each item goes through the front register, the queue and then the result register
// throughput: one item per cycle sustained, with stalls absorbed by a two-entry queue
// the rate is set by the history ring's one read and one write port in the front end
// and the per-letter difference cells, updated and registered together in the back end
// arst_n clears control state, diff cells and the found flag; the ring is not cleared
`default_nettype none

module anagram_window_search #(
	parameter int MAX_PATTERN = 64
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	aws_stream_if.sink    item,
	aws_stream_if.source  result
);

	logic           q_push_valid;
	logic           q_push_ready;
	aws_pkg::qent_t q_push_data;
	logic           q_pop_valid;
	logic           q_pop_ready;
	aws_pkg::qent_t q_pop_data;

	aws_front #(
		.MAX_PATTERN (MAX_PATTERN)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (item.valid),
		.in_ready   (item.ready),
		.in_data    (item.data),
		.push_valid (q_push_valid),
		.push_ready (q_push_ready),
		.push_data  (q_push_data)
	);

	aws_queue #(
		.T (aws_pkg::qent_t)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (q_push_valid),
		.push_ready (q_push_ready),
		.push_data  (q_push_data),
		.pop_valid  (q_pop_valid),
		.pop_ready  (q_pop_ready),
		.pop_data   (q_pop_data)
	);

	aws_back #(
		.MAX_PATTERN (MAX_PATTERN)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (q_pop_valid),
		.pop_ready (q_pop_ready),
		.pop_data  (q_pop_data),
		.res_valid (result.valid),
		.res_ready (result.ready),
		.res_data  (result.data)
	);

endmodule

`default_nettype wire

/* src/aws_checker.sv */
// port-level checker for the anagram window search block and its bind
`default_nettype none

`include "anagram_window_search_macros.svh"

module aws_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic result_valid,
	input wire logic result_ready,
	input wire logic match_here,
	input wire logic found
);

	logic [2:0] outstanding_q;
	logic       in_beat;
	logic       out_beat;

	assign in_beat  = in_valid && in_ready;
	assign out_beat = result_valid && result_ready;

	// items taken whose result beat has not gone yet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= '0;
		end else begin
			outstanding_q <= outstanding_q + 3'(in_beat) - 3'(out_beat);
		end
	end

	`AWS_ASSERT_NEXT(a_result_held, result_valid && !result_ready, result_valid)
	`AWS_ASSERT_NEXT(a_result_stable, result_valid && !result_ready, $stable({match_here, found}))
	`AWS_ASSERT_NOW(a_match_sets_found, result_valid && match_here, found)
	`AWS_ASSERT_NOW(a_no_spurious_result, result_valid, outstanding_q != 3'd0)
	`AWS_ASSERT_NOW(a_bounded_in_flight, 1'b1, outstanding_q <= 3'd4)

endmodule

bind anagram_window_search aws_checker u_aws_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (item.valid),
	.in_ready     (item.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.match_here   (result.data.match_here),
	.found        (result.data.found)
);

`default_nettype wire
